### design/sparse_array_store_defines.svh
// Assertion macros shared by the sparse array store RTL.
`ifndef SPARSE_ARRAY_STORE_DEFINES_SVH
`define SPARSE_ARRAY_STORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SAS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that the condition implies the consequence in the same cycle.
`define SAS_ASSERT_IMPL(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Check that the condition implies the consequence in the next cycle.
`define SAS_ASSERT_NEXT(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

### design/sas_pkg.sv
// Types shared by the sparse array store chain and its top level.
`default_nettype none

package sas_pkg;

   typedef enum logic {
      SAS_OP_READ  = 1'b0,
      SAS_OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      SAS_OK    = 2'd0,
      SAS_RANGE = 2'd1,
      SAS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       active;
      logic       is_write;
      logic       done;
      logic       present;
      status_type status;
   } ctrl_type;

endpackage

`default_nettype wire

### design/sas_cell.sv
// One slot of the sparse array store: holds an entry and serves the passing request.
`default_nettype none

`include "sparse_array_store_defines.svh"

module sas_cell #(
   parameter int INDEX_BITS,
   parameter int VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sas_pkg::ctrl_type     up_ctrl,
   input  logic [INDEX_BITS-1:0] up_index,
   input  logic [VALUE_BITS-1:0] up_wval,
   input  logic [VALUE_BITS-1:0] up_rval,
   output sas_pkg::ctrl_type     dn_ctrl,
   output logic [INDEX_BITS-1:0] dn_index,
   output logic [VALUE_BITS-1:0] dn_wval,
   output logic [VALUE_BITS-1:0] dn_rval
);
   import sas_pkg::*;

   logic                  slot_valid_ff;
   logic                  slot_valid_in;
   logic [INDEX_BITS-1:0] slot_index_ff;
   logic [INDEX_BITS-1:0] slot_index_in;
   logic [VALUE_BITS-1:0] slot_value_ff;
   logic [VALUE_BITS-1:0] slot_value_in;
   ctrl_type              ctrl_ff;
   ctrl_type              ctrl_in;
   logic [INDEX_BITS-1:0] index_ff;
   logic [VALUE_BITS-1:0] wval_ff;
   logic [VALUE_BITS-1:0] rval_ff;
   logic [VALUE_BITS-1:0] rval_in;
   logic                  pending;
   logic                  hit;

   assign pending = up_ctrl.active && !up_ctrl.done;
   assign hit     = slot_valid_ff && (slot_index_ff == up_index);

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_index_in = slot_index_ff;
      slot_value_in = slot_value_ff;
      ctrl_in       = up_ctrl;
      rval_in       = up_rval;
      if (pending && hit) begin
         if (up_ctrl.is_write) begin
            slot_value_in = up_wval;
            rval_in       = up_wval;
         end else begin
            rval_in = slot_value_ff;
         end
         ctrl_in.done    = 1'b1;
         ctrl_in.present = 1'b1;
      end else if (pending && !slot_valid_ff) begin
         slot_valid_in = 1'b1;
         slot_index_in = up_index;
         slot_value_in = up_ctrl.is_write ? up_wval : '0;
         rval_in       = up_ctrl.is_write ? up_wval : '0;
         ctrl_in.done  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         ctrl_ff       <= '0;
      end else if (advance) begin
         slot_valid_ff <= slot_valid_in;
         ctrl_ff       <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_index_ff <= slot_index_in;
         slot_value_ff <= slot_value_in;
         index_ff      <= up_index;
         wval_ff       <= up_wval;
         rval_ff       <= rval_in;
      end
   end

   assign dn_ctrl  = ctrl_ff;
   assign dn_index = index_ff;
   assign dn_wval  = wval_ff;
   assign dn_rval  = rval_ff;

   `SAS_ASSERT(a_slot_kept, !$fell(slot_valid_ff), "slot entry dropped without reset")
   `SAS_ASSERT_NEXT(a_hit_served, advance && pending && hit, dn_ctrl.done && dn_ctrl.present, "matching slot did not serve request")
   `SAS_ASSERT_NEXT(a_free_filled, advance && pending && !slot_valid_ff, slot_valid_ff, "free slot not filled")

endmodule

`default_nettype wire

### design/sparse_array_store.sv
// Top level of the sparse array store: request entry, slot chain and response register.
//
// Requests arrive on req_* (valid/ready) with an opcode, an element index and a
// write value. Each request walks a chain of CAPACITY slot cells, one cell per cycle
// while not frozen; a cell whose entry matches the index serves it, and the first
// empty cell takes a new entry. A request that finds neither comes out as table full.
// Indexes at or above the logical size register are refused at entry.
// The logical size is written on csr_* (valid/ready, always ready); the user must do so
// only while idle, as the block itself does not enforce it.
// Only one request walks the chain at a time, as req_ready is low until it leaves;
// the next request may enter while the previous response waits on rsp_*.
// A stalled rsp_ready holds a request that reaches the chain end in the last cell
// and freezes the chain until the response register frees up.
// Reset clears every slot, the logical size and all handshake state.
`default_nettype none

`include "sparse_array_store_defines.svh"

module sparse_array_store #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 8,
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [INDEX_BITS-1:0] csr_logical_size,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sas_pkg::opcode_type   req_opcode,
   input  logic [INDEX_BITS-1:0] req_element_index,
   input  logic [VALUE_BITS-1:0] req_write_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic                  rsp_entry_was_present,
   output sas_pkg::status_type   rsp_status
);
   import sas_pkg::*;

   logic [INDEX_BITS-1:0] logical_size_ff;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_read_value_ff;
   logic                  rsp_present_ff;
   status_type            rsp_status_ff;
   logic                  req_accept;
   logic                  beyond_size;
   logic                  advance;
   logic                  chain_exit;
   ctrl_type              entry_ctrl;

   ctrl_type              chain_ctrl  [CAPACITY+1];
   logic [INDEX_BITS-1:0] chain_index [CAPACITY+1];
   logic [VALUE_BITS-1:0] chain_wval  [CAPACITY+1];
   logic [VALUE_BITS-1:0] chain_rval  [CAPACITY+1];

   assign csr_ready  = 1'b1;
   assign req_ready  = !busy_ff;
   assign req_accept = req_valid && req_ready;

   assign beyond_size = (req_element_index >= logical_size_ff);
   assign chain_exit  = chain_ctrl[CAPACITY].active;
   assign advance     = !(chain_exit && rsp_valid_ff && !rsp_ready);

   always_comb begin
      entry_ctrl.active   = req_accept;
      entry_ctrl.is_write = (req_opcode == SAS_OP_WRITE);
      entry_ctrl.done     = beyond_size;
      entry_ctrl.present  = 1'b0;
      entry_ctrl.status   = beyond_size ? SAS_RANGE : SAS_OK;
   end

   assign chain_ctrl[0]  = entry_ctrl;
   assign chain_index[0] = req_element_index;
   assign chain_wval[0]  = req_write_value;
   assign chain_rval[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sas_cell #(
         .INDEX_BITS (INDEX_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_ctrl  (chain_ctrl[i]),
         .up_index (chain_index[i]),
         .up_wval  (chain_wval[i]),
         .up_rval  (chain_rval[i]),
         .dn_ctrl  (chain_ctrl[i+1]),
         .dn_index (chain_index[i+1]),
         .dn_wval  (chain_wval[i+1]),
         .dn_rval  (chain_rval[i+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (chain_exit && advance) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (chain_exit && advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         logical_size_ff <= '0;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            logical_size_ff <= csr_logical_size;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_exit && advance) begin
         if (chain_ctrl[CAPACITY].done) begin
            rsp_read_value_ff <= chain_rval[CAPACITY];
            rsp_present_ff    <= chain_ctrl[CAPACITY].present;
            rsp_status_ff     <= chain_ctrl[CAPACITY].status;
         end else begin
            rsp_read_value_ff <= '0;
            rsp_present_ff    <= 1'b0;
            rsp_status_ff     <= SAS_FULL;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_value        = rsp_read_value_ff;
   assign rsp_entry_was_present = rsp_present_ff;
   assign rsp_status            = rsp_status_ff;

   `SAS_ASSERT_NEXT(a_accept_busy, req_accept, busy_ff, "accepted request did not mark busy")
   `SAS_ASSERT_IMPL(a_exit_busy, chain_exit, busy_ff, "request left chain while idle")
   `SAS_ASSERT_IMPL(a_idle_flows, !busy_ff, advance, "chain frozen with no request in flight")
   `SAS_ASSERT_IMPL(a_range_result, rsp_valid_ff && rsp_status_ff == SAS_RANGE,
      rsp_read_value_ff == '0 && !rsp_present_ff, "refused request carries data")

endmodule

`default_nettype wire

### bench/sparse_array_store_tb.sv
// Self-checking testbench for sparse_array_store: directed table, then random access phases.
module sparse_array_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sas_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int HALF_PERIOD = 10;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_ITEMS = 225;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [7:0] value;
      logic       present;
      status_type status;
   } lookup_outcome_type;

   typedef struct {
      bit          is_cfg;
      opcode_type  op;
      logic [15:0] idx;
      logic [7:0]  val;
      bit          typed;
      logic [7:0]  exp_value;
      logic        exp_present;
      status_type  exp_status;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_logical_size = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   opcode_type  req_opcode = SAS_OP_READ;
   logic [15:0] req_element_index = '0;
   logic [7:0]  req_write_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_value;
   logic        rsp_entry_was_present;
   status_type  rsp_status;

   // predictor state
   logic [15:0] store_size = '0;
   logic [15:0] store_pos [CAPACITY];
   logic [7:0]  store_val [CAPACITY];
   int          store_count = 0;

   lookup_outcome_type pending_outcomes[$];
   bit                 row_checked = 1'b0;
   lookup_outcome_type row_result = '0;

   int sent_total = 0;
   int answered_total = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int burst_left = 0;
   int phase_no = -1;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic [8:0] beat = '0;

   step_row_type directed_rows[25] = '{
      '{1'b0, SAS_OP_READ,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0, SAS_RANGE},
      '{1'b0, SAS_OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, 8'h00, 1'b0, SAS_RANGE},
      '{1'b1, SAS_OP_READ,  16'hFFFF, 8'h00, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_READ,  16'hFFFF, 8'h00, 1'b1, 8'h00, 1'b0, SAS_RANGE},
      '{1'b0, SAS_OP_READ,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0000, 8'hFF, 1'b1, 8'hFF, 1'b1, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'hFFFE, 8'hA5, 1'b1, 8'hA5, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_READ,  16'hFFFE, 8'h00, 1'b1, 8'hA5, 1'b1, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b1, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0001, 8'h01, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_READ,  16'h0002, 8'h00, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0004, 8'h80, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0008, 8'h7F, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0010, 8'h55, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_READ,  16'h0020, 8'hAA, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0040, 8'h33, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0080, 8'hCC, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0100, 8'h0F, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0200, 8'hF0, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_READ,  16'h0400, 8'h00, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h0800, 8'h3C, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h1000, 8'hC3, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h2000, 8'h99, 1'b0, 8'h00, 1'b0, SAS_OK},
      '{1'b0, SAS_OP_WRITE, 16'h7777, 8'h5A, 1'b1, 8'h00, 1'b0, SAS_FULL},
      '{1'b0, SAS_OP_READ,  16'hFFFE, 8'h00, 1'b1, 8'hA5, 1'b1, SAS_OK}
   };

   sparse_array_store dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_logical_size      (csr_logical_size),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_element_index     (req_element_index),
      .req_write_value       (req_write_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_value        (rsp_read_value),
      .rsp_entry_was_present (rsp_entry_was_present),
      .rsp_status            (rsp_status)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic lookup_outcome_type access_table(opcode_type op, logic [15:0] idx,
                                                       logic [7:0] val);
      lookup_outcome_type res;
      int hit;
      res = '{value: 8'h00, present: 1'b0, status: SAS_OK};
      hit = -1;
      if (idx >= store_size) begin
         res.status = SAS_RANGE;
      end else begin
         for (int i = 0; i < store_count; i++) begin
            if (hit < 0 && store_pos[i] == idx) hit = i;
         end
         if (hit >= 0) begin
            if (op == SAS_OP_WRITE) store_val[hit] = val;
            res.value = store_val[hit];
            res.present = 1'b1;
         end else if (store_count >= CAPACITY) begin
            res.status = SAS_FULL;
         end else begin
            store_pos[store_count] = idx;
            store_val[store_count] = (op == SAS_OP_WRITE) ? val : 8'h00;
            res.value = store_val[store_count];
            store_count++;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch %0d at %0t: %s got %0d want %0d", mismatches, $realtime, field,
                  got, want);
   endtask

   task automatic issue(opcode_type op, logic [15:0] idx, logic [7:0] val, bit typed,
                        lookup_outcome_type want);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_element_index <= idx;
      req_write_value <= val;
      row_checked <= typed;
      row_result <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_total++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_size(logic [15:0] size);
      req_valid <= 1'b0;
      while (answered_total != sent_total) @(posedge clock);
      repeat (2 * CAPACITY) @(posedge clock);
      csr_valid <= 1'b1;
      csr_logical_size <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: one long hold-off in phase 2, otherwise a rotating stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (phase_no == 2 && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         beat <= beat + 1'b1;
         case (beat[8:6])
            3'd0, 3'd1: rsp_ready <= 1'b1;
            3'd2: rsp_ready <= ($urandom_range(0, 1) != 0);
            3'd3: rsp_ready <= (beat[1:0] == 2'd0);
            3'd4: rsp_ready <= beat[3];
            default: rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      lookup_outcome_type got;
      lookup_outcome_type want;
      lookup_outcome_type predicted;
      if (!reset) begin
         if (csr_valid && csr_ready) store_size = csr_logical_size;
         if (req_valid && req_ready) begin
            predicted = access_table(req_opcode, req_element_index, req_write_value);
            pending_outcomes.insert(pending_outcomes.size(),
                                    row_checked ? row_result : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            answered_total++;
            got = '{value: rsp_read_value, present: rsp_entry_was_present, status: rsp_status};
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (got.value !== want.value) report_mismatch("read_value", got.value, want.value);
               if (got.present !== want.present)
                  report_mismatch("entry_was_present", got.present, want.present);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      step_row_type       row;
      lookup_outcome_type want;
      opcode_type         op;
      logic [15:0]        idx;
      logic [7:0]         val;
      int                 pick;
      logic [15:0]        phase_size [6];
      phase_size[0] = 16'hFFFF;
      phase_size[1] = 16'h0000;
      phase_size[2] = 16'($urandom_range(1, 65534));
      phase_size[3] = 16'h0001;
      phase_size[4] = 16'($urandom_range(1, 65534));
      phase_size[5] = 16'h8000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.is_cfg) begin
            write_size(row.idx);
         end else begin
            want = '{value: row.exp_value, present: row.exp_present, status: row.exp_status};
            issue(row.op, row.idx, row.val, row.typed, want);
         end
      end
      for (int p = 0; p < 6; p++) begin
         write_size(phase_size[p]);
         phase_no = p;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            op = ($urandom_range(0, 1) != 0) ? SAS_OP_WRITE : SAS_OP_READ;
            if ($urandom_range(0, 7) == 0)
               val = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            else
               val = 8'($urandom_range(0, 255));
            if (pick < 55 && store_count > 0)
               idx = store_pos[$urandom_range(0, store_count - 1)];
            else if (pick < 80)
               idx = store_size + 16'($urandom_range(0, 2)) - 16'd1;
            else
               idx = 16'($urandom_range(0, 65535));
            issue(op, idx, val, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      while (answered_total != sent_total) @(posedge clock);
      repeat (2 * CAPACITY) @(posedge clock);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
